>>> rtl/icfm_pkg.sv
// Shared types and constants for the interval coverage filter and merger.
package icfm_pkg;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TOTAL_W = 38;
   localparam int PROD_W = 54;
   localparam int COV_W = 7;
   localparam int RESULT_LIMIT = 32;
   localparam int KCNT_W = 6;

   localparam logic [CSR_IDX_W-1:0] CSR_TRIM_CUTOFF = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MERGE_OVERLAP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_QUALITY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_COVERAGE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COVERAGE_RATIO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_LENGTH = 3'd6;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef struct packed {
      logic        we;
      logic        shift;
      logic        clr_best;
      logic        filt;
   } cell_ctl_type;

   typedef struct packed {
      logic [31:0] start;
      logic [31:0] stop;
      logic        keep;
   } entry_type;

   typedef struct packed {
      logic              valid;
      logic              phase;
      logic [32:0]       pos;
      logic [COV_W-1:0]  count;
   } token_type;

endpackage

>>> rtl/icfm_cell.sv
// One storage cell: holds an alignment, counts coverage of passing tokens, shifts out.
module icfm_cell import icfm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [19:0]       cutoff,
   input  logic [COV_W-1:0]  thr,
   input  logic [31:0]       wr_start,
   input  logic [31:0]       wr_end,
   input  entry_type         next_entry,
   output entry_type         entry,
   input  token_type         tok_in,
   output token_type         tok_out
);

   entry_type         entry_ff, entry_in;
   token_type         tok_ff, tok_in_r;
   logic [COV_W-1:0]  best_ff, best_in;
   logic [32:0]       span_a, span_b;
   logic              covers;

   assign span_a = {1'b0, entry_ff.start} + {13'd0, cutoff};
   assign span_b = {1'b0, entry_ff.stop} - {13'd0, cutoff};
   assign covers = entry_ff.keep && tok_in.valid &&
                   (span_a <= tok_in.pos) && (tok_in.pos < span_b);

   always_comb begin
      tok_in_r = tok_in;
      if (!tok_in.phase && covers) begin
         tok_in_r.count = tok_in.count + COV_W'(1);
      end
   end

   always_comb begin
      best_in = best_ff;
      if (ctl.clr_best) begin
         best_in = '0;
      end else if (tok_in.phase && covers && (tok_in.count > best_ff)) begin
         best_in = tok_in.count;
      end
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.we) begin
         entry_in.start = wr_start;
         entry_in.stop = wr_end;
         entry_in.keep = 1'b1;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end else if (ctl.filt) begin
         entry_in.keep = entry_ff.keep && (best_ff >= thr);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.keep <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         entry_ff.keep <= entry_in.keep;
         tok_ff.valid <= tok_in_r.valid;
      end
      entry_ff.start <= entry_in.start;
      entry_ff.stop <= entry_in.stop;
      tok_ff.phase <= tok_in_r.phase;
      tok_ff.pos <= tok_in_r.pos;
      tok_ff.count <= tok_in_r.count;
      best_ff <= best_in;
   end

   assign entry = entry_ff;
   assign tok_out = tok_ff;

endmodule

>>> rtl/icfm_div.sv
// Restoring divider, one quotient bit per cycle.
module icfm_div import icfm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [TOTAL_W-1:0] dividend,
   input  logic [31:0]        divisor,
   output logic [TOTAL_W-1:0] quotient,
   output logic               busy
);

   localparam int CW = $clog2(TOTAL_W + 1);

   logic [TOTAL_W-1:0] num_ff, num_in;
   logic [31:0]        rem_ff, rem_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [32:0]        rem_sh;
   logic               ge;

   assign rem_sh = {rem_ff, num_ff[TOTAL_W-1]};
   assign ge = rem_sh >= {1'b0, divisor};

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         num_in = dividend;
         rem_in = '0;
         cnt_in = CW'(TOTAL_W);
      end else if (cnt_ff != '0) begin
         rem_in = ge ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];
         num_in = {num_ff[TOTAL_W-2:0], ge};
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign quotient = num_ff;
   assign busy = cnt_ff != '0;

endmodule

>>> rtl/interval_coverage_filter_merge.sv
// Top level: alignment store as a chain of cells, coverage filter and segment merger.
// Load: one item per cycle while idle, no result. Finish: a multiply, a divide, token
// passes through the cell chain, a filter step, then a merge over the stored alignments
// that ends with a closing result; rsp_stall holds the merge.
// Synchronous active-high reset clears store flags and counters and resets the CSRs.
module interval_coverage_filter_merge import icfm_pkg::*; #(
   parameter int MAX_ALNS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_cmd,
   input  logic [31:0]           req_aln_start,
   input  logic [31:0]           req_aln_end,
   input  logic [7:0]            req_quality,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [31:0]           rsp_seg_start,
   output logic [31:0]           rsp_seg_end,
   output logic                  rsp_seg_valid,
   output logic                  rsp_overflowed,
   output logic                  rsp_last
);

   localparam int IDXW = $clog2(MAX_ALNS);
   localparam int CNTW = $clog2(MAX_ALNS + 1);
   localparam int STEPW = $clog2(3 * MAX_ALNS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL = 3'd1;
   localparam logic [2:0] ST_DIVS = 3'd2;
   localparam logic [2:0] ST_DIV = 3'd3;
   localparam logic [2:0] ST_COV = 3'd4;
   localparam logic [2:0] ST_FILT = 3'd5;
   localparam logic [2:0] ST_MERGE = 3'd6;

   logic [19:0] cut_ff;
   logic [31:0] ovl_ff, minlen_ff, ref_ff;
   logic [7:0]  minq_ff;
   logic [6:0]  mincov_ff;
   logic [15:0] ratio_ff;

   logic [2:0]          state_ff, state_in;
   logic [CNTW-1:0]     count_ff, count_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic                ovf_ff, ovf_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [STEPW-1:0]    step_ff, step_in;
   logic                open_ff, open_in;
   logic [31:0]         segs_ff, segs_in, sege_ff, sege_in;
   logic [KCNT_W:0]     k_ff, k_in;

   logic        rv_ff, rv_in;
   logic [31:0] rs_ff, rs_in, re_ff, re_in;
   logic        rsv_ff, rsv_in, rovf_ff, rovf_in, rlast_ff, rlast_in;

   logic [TOTAL_W-1:0] quot;
   logic               div_busy, div_start;
   logic [31:0]        ref_eff;
   logic [COV_W-1:0]   thr_sat, thr;

   cell_ctl_type ctl [MAX_ALNS];
   entry_type    ent [MAX_ALNS];
   entry_type    nxt [MAX_ALNS];
   token_type    tok [MAX_ALNS+1];

   logic        accept, out_free;
   logic [31:0] len;
   logic [32:0] eff_len, two_cut_p1;
   logic        keep_new;
   entry_type   head;
   logic        split;

   assign accept = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;
   assign out_free = !rv_ff || !rsp_stall;
   assign head = ent[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_ff <= '0;
         ovl_ff <= '0;
         minlen_ff <= '0;
         minq_ff <= '0;
         mincov_ff <= '0;
         ratio_ff <= '0;
         ref_ff <= 32'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TRIM_CUTOFF: cut_ff <= csr_wdata[19:0];
            CSR_MERGE_OVERLAP: ovl_ff <= csr_wdata;
            CSR_MIN_LENGTH: minlen_ff <= csr_wdata;
            CSR_MIN_QUALITY: minq_ff <= csr_wdata[7:0];
            CSR_MIN_COVERAGE: mincov_ff <= csr_wdata[6:0];
            CSR_COVERAGE_RATIO: ratio_ff <= csr_wdata[15:0];
            CSR_REFERENCE_LENGTH: ref_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign len = (req_aln_end >= req_aln_start) ? (req_aln_end - req_aln_start) : 32'd0;
   assign two_cut_p1 = {12'd0, cut_ff, 1'b1};
   assign eff_len = ({1'b0, minlen_ff} > two_cut_p1) ? {1'b0, minlen_ff} : two_cut_p1;
   assign keep_new = ({1'b0, len} >= eff_len) && (req_quality >= minq_ff);

   assign ref_eff = (ref_ff == '0) ? 32'd1 : ref_ff;
   assign div_start = state_ff == ST_DIVS;

   icfm_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(prod_ff[PROD_W-1:16]),
      .divisor(ref_eff),
      .quotient(quot),
      .busy(div_busy)
   );

   assign thr_sat = (|quot[TOTAL_W-1:COV_W]) ? {COV_W{1'b1}} : quot[COV_W-1:0];
   assign thr = (thr_sat < mincov_ff) ? mincov_ff : thr_sat;

   always_comb begin
      tok[0] = '0;
      if (tok[MAX_ALNS].valid && !tok[MAX_ALNS].phase) begin
         tok[0] = tok[MAX_ALNS];
         tok[0].phase = 1'b1;
      end else if (state_ff == ST_COV && step_ff < STEPW'(count_ff)) begin
         tok[0].valid = 1'b1;
         tok[0].phase = 1'b0;
         tok[0].pos = {1'b0, ent[step_ff[IDXW-1:0]].start} + {13'd0, cut_ff};
         tok[0].count = '0;
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_ALNS; g++) begin : g_cell
         always_comb begin
            ctl[g].we = accept && req_cmd == CMD_LOAD && keep_new &&
                        count_ff < CNTW'(MAX_ALNS) && count_ff == CNTW'(g);
            ctl[g].shift = state_ff == ST_MERGE && out_free &&
                           count_ff != '0 && step_ff < STEPW'(count_ff);
            ctl[g].clr_best = state_ff == ST_MUL;
            ctl[g].filt = state_ff == ST_FILT;
         end
         if (g == MAX_ALNS - 1) begin : g_tail
            assign nxt[g] = '0;
         end else begin : g_mid
            assign nxt[g] = ent[g+1];
         end
         icfm_cell u_cell (
            .clock(clock),
            .reset(reset),
            .ctl(ctl[g]),
            .cutoff(cut_ff),
            .thr(thr),
            .wr_start(req_aln_start),
            .wr_end(req_aln_end),
            .next_entry(nxt[g]),
            .entry(ent[g]),
            .tok_in(tok[g]),
            .tok_out(tok[g+1])
         );
      end
   endgenerate

   assign split = {1'b0, sege_ff} <= ({1'b0, head.start} + {1'b0, ovl_ff});

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      total_in = total_ff;
      ovf_in = ovf_ff;
      step_in = step_ff;
      open_in = open_ff;
      segs_in = segs_ff;
      sege_in = sege_ff;
      k_in = k_ff;
      rv_in = rv_ff && rsp_stall;
      rs_in = rs_ff;
      re_in = re_ff;
      rsv_in = rsv_ff;
      rovf_in = rovf_ff;
      rlast_in = rlast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_FINISH) begin
                  state_in = ST_MUL;
               end else if (keep_new) begin
                  if (count_ff >= CNTW'(MAX_ALNS)) begin
                     ovf_in = 1'b1;
                  end else begin
                     count_in = count_ff + CNTW'(1);
                     total_in = total_ff + TOTAL_W'(len) - TOTAL_W'({cut_ff, 1'b0});
                  end
               end
            end
         end
         ST_MUL: state_in = ST_DIVS;
         ST_DIVS: state_in = ST_DIV;
         ST_DIV: begin
            step_in = '0;
            if (!div_busy) begin
               state_in = ST_COV;
            end
         end
         ST_COV: begin
            step_in = step_ff + STEPW'(1);
            if (step_ff == STEPW'(3 * MAX_ALNS - 1)) begin
               state_in = ST_FILT;
            end
         end
         ST_FILT: begin
            state_in = ST_MERGE;
            step_in = '0;
            open_in = 1'b0;
            k_in = '0;
         end
         ST_MERGE: begin
            if (out_free) begin
               if (step_ff < STEPW'(count_ff)) begin
                  step_in = step_ff + STEPW'(1);
                  if (head.keep) begin
                     if (!open_ff) begin
                        open_in = 1'b1;
                        segs_in = head.start;
                        sege_in = head.stop;
                     end else if (split) begin
                        if (k_ff < (KCNT_W+1)'(RESULT_LIMIT)) begin
                           rv_in = 1'b1;
                           rs_in = segs_ff;
                           re_in = sege_ff;
                           rsv_in = 1'b1;
                           rovf_in = ovf_ff;
                           rlast_in = k_ff == (KCNT_W+1)'(RESULT_LIMIT - 1);
                           k_in = k_ff + (KCNT_W+1)'(1);
                        end
                        segs_in = head.start;
                        sege_in = head.stop;
                     end else if (sege_ff < head.stop) begin
                        sege_in = head.stop;
                     end
                  end
               end else begin
                  if (k_ff < (KCNT_W+1)'(RESULT_LIMIT)) begin
                     rv_in = 1'b1;
                     rs_in = open_ff ? segs_ff : 32'd0;
                     re_in = open_ff ? sege_ff : 32'd0;
                     rsv_in = open_ff;
                     rovf_in = ovf_ff;
                     rlast_in = 1'b1;
                  end
                  state_in = ST_IDLE;
                  count_in = '0;
                  total_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         ovf_ff <= 1'b0;
         step_ff <= '0;
         open_ff <= 1'b0;
         k_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         total_ff <= total_in;
         ovf_ff <= ovf_in;
         step_ff <= step_in;
         open_ff <= open_in;
         k_ff <= k_in;
         rv_ff <= rv_in;
      end
      segs_ff <= segs_in;
      sege_ff <= sege_in;
      rs_ff <= rs_in;
      re_ff <= re_in;
      rsv_ff <= rsv_in;
      rovf_ff <= rovf_in;
      rlast_ff <= rlast_in;
      prod_ff <= PROD_W'(total_ff) * PROD_W'(ratio_ff);
   end

   assign rsp_valid = rv_ff;
   assign rsp_seg_start = rs_ff;
   assign rsp_seg_end = re_ff;
   assign rsp_seg_valid = rsv_ff;
   assign rsp_overflowed = rovf_ff;
   assign rsp_last = rlast_ff;

endmodule
